>>> rtl/core/camera_visibility_score_top_assert.svh
// Assertion macros for the camera visibility score block.
`ifndef CAMERA_VISIBILITY_SCORE_TOP_ASSERT_SVH
`define CAMERA_VISIBILITY_SCORE_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define CVS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define CVS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/cvs_pkg.sv
// Shared types, constants and the sigmoid node table for the visibility score block.
package cvs_pkg;

   localparam int NormWidth     = 32;
   localparam int DivSteps      = 31;
   localparam int SqrtSteps     = 16;
   localparam int RatioWidth    = 16;
   localparam int SqrtRemWidth  = RatioWidth + 3;
   localparam int SigWidth      = 17;
   localparam int Lanes         = 3;
   localparam int CsrIndexWidth = 2;

   localparam int LaneVert  = 0;
   localparam int LaneAxis  = 1;
   localparam int LaneHoriz = 2;

   localparam logic [CsrIndexWidth-1:0] CfgModelSelect = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CfgCosVert     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CfgCosHoriz    = 2'd2;

   localparam logic ModelProposed = 1'b0;
   localparam logic ModelConical  = 1'b1;

   localparam logic [15:0] CosVertReset  = 16'd28378;
   localparam logic [15:0] CosHorizReset = 16'd23170;

   localparam logic [5:0] SigGain [Lanes] = '{6'd40, 6'd10, 6'd20};

   typedef logic [NormWidth-1:0]  norm_type;
   typedef logic [RatioWidth-1:0] ratio_type;
   typedef logic [SigWidth-1:0]   sig_type;

   localparam sig_type SigOne = 17'd65536;

   typedef struct packed {
      logic valid;
      logic zero;
      logic x_neg;
   } ctl_type;

   // Logistic nodes at half steps of the argument, 65536 at the end.
   function automatic sig_type sig_node(input logic [4:0] idx);
      sig_type v;
      case (idx)
         5'd0:    v = 17'd32768;
         5'd1:    v = 17'd40793;
         5'd2:    v = 17'd47910;
         5'd3:    v = 17'd53581;
         5'd4:    v = 17'd57724;
         5'd5:    v = 17'd60564;
         5'd6:    v = 17'd62428;
         5'd7:    v = 17'd63615;
         5'd8:    v = 17'd64357;
         5'd9:    v = 17'd64816;
         5'd10:   v = 17'd65097;
         5'd11:   v = 17'd65269;
         5'd12:   v = 17'd65374;
         5'd13:   v = 17'd65438;
         5'd14:   v = 17'd65476;
         5'd15:   v = 17'd65500;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/core/cvs_front.sv
// Front stages: magnitudes, squares, sums and normalization to 32 bits.
module cvs_front
   import cvs_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   output ctl_type                       out_ctl,
   output norm_type                      out_den,
   output norm_type [Lanes-1:0]          out_num
);

   localparam int SqWidth  = 2 * COORD_WIDTH;
   localparam int SumWidth = SqWidth + 2;

   typedef logic [SumWidth-1:0] sum_type;

   function automatic logic need_shift(input sum_type den, input int sh);
      return (den >> (NormWidth + sh)) != '0;
   endfunction

   ctl_type ctl1_in, ctl1_ff, ctl2_ff, ctl3_in, ctl3_ff, ctl4_in, ctl4_ff, ctl5_in, ctl5_ff;
   logic [COORD_WIDTH-1:0] ax1_in, ay1_in, az1_in, ax1_ff, ay1_ff, az1_ff;
   logic [SqWidth-1:0] xx2_in, yy2_in, zz2_in, xx2_ff, yy2_ff, zz2_ff;
   sum_type den3_in, den3_ff, den4_in, den4_ff, den5_in, den5_ff;
   sum_type [Lanes-1:0] num3_in, num3_ff, num4_in, num4_ff, num5_in, num5_ff;

   // Take magnitudes and keep the sign of x
   always_comb begin
      ctl1_in.valid = in_valid;
      ctl1_in.zero  = 1'b0;
      ctl1_in.x_neg = pos_x[COORD_WIDTH-1];
      ax1_in = pos_x[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_x) : COORD_WIDTH'(pos_x);
      ay1_in = pos_y[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_y) : COORD_WIDTH'(pos_y);
      az1_in = pos_z[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_z) : COORD_WIDTH'(pos_z);
   end

   // Square each magnitude
   always_comb begin
      xx2_in = SqWidth'(ax1_ff) * SqWidth'(ax1_ff);
      yy2_in = SqWidth'(ay1_ff) * SqWidth'(ay1_ff);
      zz2_in = SqWidth'(az1_ff) * SqWidth'(az1_ff);
   end

   // Form the length squared and the three numerators, flag the origin
   always_comb begin
      ctl3_in = ctl2_ff;
      ctl3_in.zero = (xx2_ff == '0) && (yy2_ff == '0) && (zz2_ff == '0);
      num3_in[LaneAxis]  = SumWidth'(xx2_ff);
      num3_in[LaneVert]  = SumWidth'(xx2_ff) + SumWidth'(yy2_ff);
      num3_in[LaneHoriz] = SumWidth'(xx2_ff) + SumWidth'(zz2_ff);
      den3_in = SumWidth'(xx2_ff) + SumWidth'(yy2_ff) + SumWidth'(zz2_ff);
   end

   // Coarse normalization: shift by 16, 8, 4 while the length squared is too wide
   always_comb begin
      ctl4_in = ctl3_ff;
      den4_in = den3_ff;
      num4_in = num3_ff;
      if (need_shift(den4_in, 16)) begin
         den4_in = den4_in >> 16;
         for (int l = 0; l < Lanes; l++) num4_in[l] = num4_in[l] >> 16;
      end
      if (need_shift(den4_in, 8)) begin
         den4_in = den4_in >> 8;
         for (int l = 0; l < Lanes; l++) num4_in[l] = num4_in[l] >> 8;
      end
      if (need_shift(den4_in, 4)) begin
         den4_in = den4_in >> 4;
         for (int l = 0; l < Lanes; l++) num4_in[l] = num4_in[l] >> 4;
      end
   end

   // Fine normalization: shift by 2, 1, 1
   always_comb begin
      ctl5_in = ctl4_ff;
      den5_in = den4_ff;
      num5_in = num4_ff;
      if (need_shift(den5_in, 2)) begin
         den5_in = den5_in >> 2;
         for (int l = 0; l < Lanes; l++) num5_in[l] = num5_in[l] >> 2;
      end
      if (need_shift(den5_in, 1)) begin
         den5_in = den5_in >> 1;
         for (int l = 0; l < Lanes; l++) num5_in[l] = num5_in[l] >> 1;
      end
      if (need_shift(den5_in, 0)) begin
         den5_in = den5_in >> 1;
         for (int l = 0; l < Lanes; l++) num5_in[l] = num5_in[l] >> 1;
      end
   end

   // Advance control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl3_in;
         ctl4_ff <= ctl4_in;
         ctl5_ff <= ctl5_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         ax1_ff  <= ax1_in;
         ay1_ff  <= ay1_in;
         az1_ff  <= az1_in;
         xx2_ff  <= xx2_in;
         yy2_ff  <= yy2_in;
         zz2_ff  <= zz2_in;
         den3_ff <= den3_in;
         num3_ff <= num3_in;
         den4_ff <= den4_in;
         num4_ff <= num4_in;
         den5_ff <= den5_in;
         num5_ff <= num5_in;
      end
   end

   always_comb begin
      out_ctl = ctl5_ff;
      out_den = NormWidth'(den5_ff);
      for (int l = 0; l < Lanes; l++) out_num[l] = NormWidth'(num5_ff[l]);
   end

endmodule

>>> rtl/core/cvs_ratio.sv
// Ratio pipeline: one quotient bit per stage, then one root bit per stage, three lanes.
module cvs_ratio
   import cvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ctl_type               in_ctl,
   input  norm_type              in_den,
   input  norm_type [Lanes-1:0]  in_num,
   output ctl_type               out_ctl,
   output ratio_type [Lanes-1:0] out_ratio
);

   ctl_type              dctl_ff [DivSteps];
   norm_type             dden_ff [DivSteps];
   logic [NormWidth:0]   drem_ff [DivSteps][Lanes];
   logic [DivSteps-1:0]  dquo_ff [DivSteps][Lanes];

   ctl_type                 sctl_ff  [SqrtSteps];
   logic [SqrtRemWidth-1:0] srem_ff  [SqrtSteps][Lanes];
   ratio_type               sroot_ff [SqrtSteps][Lanes];
   norm_type                srad_ff  [SqrtSteps][Lanes];

   // Restoring divider: numerator shifted up by 30 over the length squared
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      ctl_type             src_ctl;
      norm_type            src_den;
      logic [NormWidth:0]  src_rem [Lanes];
      logic [DivSteps-1:0] src_quo [Lanes];
      logic [NormWidth:0]  rem_in  [Lanes];
      logic [DivSteps-1:0] quo_in  [Lanes];
      logic [Lanes-1:0]    ge;

      if (k == 0) begin : g_head
         always_comb begin
            src_ctl = in_ctl;
            src_den = in_den;
            for (int l = 0; l < Lanes; l++) begin
               src_rem[l] = {1'b0, in_num[l]};
               src_quo[l] = '0;
            end
         end
      end else begin : g_body
         always_comb begin
            src_ctl = dctl_ff[k-1];
            src_den = dden_ff[k-1];
            for (int l = 0; l < Lanes; l++) begin
               src_rem[l] = {drem_ff[k-1][l][NormWidth-1:0], 1'b0};
               src_quo[l] = dquo_ff[k-1][l];
            end
         end
      end

      // Subtract where it fits and record the quotient bit
      always_comb begin
         for (int l = 0; l < Lanes; l++) begin
            ge[l]     = src_rem[l] >= {1'b0, src_den};
            rem_in[l] = ge[l] ? src_rem[l] - {1'b0, src_den} : src_rem[l];
            quo_in[l] = {src_quo[l][DivSteps-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dctl_ff[k] <= '0;
         end else if (advance) begin
            dctl_ff[k] <= src_ctl;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dden_ff[k] <= src_den;
            for (int l = 0; l < Lanes; l++) begin
               drem_ff[k][l] <= rem_in[l];
               dquo_ff[k][l] <= quo_in[l];
            end
         end
      end
   end

   // Digit-by-digit square root of the quotient, two radicand bits per stage
   for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
      ctl_type                 src_ctl;
      logic [SqrtRemWidth-1:0] src_rem  [Lanes];
      ratio_type               src_root [Lanes];
      norm_type                src_rad  [Lanes];
      logic [SqrtRemWidth-1:0] trial    [Lanes];
      logic [SqrtRemWidth-1:0] part     [Lanes];
      logic [SqrtRemWidth-1:0] rem_in   [Lanes];
      ratio_type               root_in  [Lanes];
      norm_type                rad_in   [Lanes];
      logic [Lanes-1:0]        ge;

      if (j == 0) begin : g_head
         always_comb begin
            src_ctl = dctl_ff[DivSteps-1];
            for (int l = 0; l < Lanes; l++) begin
               src_rem[l]  = '0;
               src_root[l] = '0;
               src_rad[l]  = NormWidth'(dquo_ff[DivSteps-1][l]);
            end
         end
      end else begin : g_body
         always_comb begin
            src_ctl = sctl_ff[j-1];
            for (int l = 0; l < Lanes; l++) begin
               src_rem[l]  = srem_ff[j-1][l];
               src_root[l] = sroot_ff[j-1][l];
               src_rad[l]  = srad_ff[j-1][l];
            end
         end
      end

      // Bring down two bits and try the next root bit
      always_comb begin
         for (int l = 0; l < Lanes; l++) begin
            part[l]    = {src_rem[l][SqrtRemWidth-3:0], src_rad[l][NormWidth-1 -: 2]};
            trial[l]   = {1'b0, src_root[l], 2'b01};
            ge[l]      = part[l] >= trial[l];
            rem_in[l]  = ge[l] ? part[l] - trial[l] : part[l];
            root_in[l] = {src_root[l][RatioWidth-2:0], ge[l]};
            rad_in[l]  = {src_rad[l][NormWidth-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sctl_ff[j] <= '0;
         end else if (advance) begin
            sctl_ff[j] <= src_ctl;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            for (int l = 0; l < Lanes; l++) begin
               srem_ff[j][l]  <= rem_in[l];
               sroot_ff[j][l] <= root_in[l];
               srad_ff[j][l]  <= rad_in[l];
            end
         end
      end
   end

   always_comb begin
      out_ctl = sctl_ff[SqrtSteps-1];
      for (int l = 0; l < Lanes; l++) out_ratio[l] = sroot_ff[SqrtSteps-1][l];
   end

endmodule

>>> rtl/core/cvs_score.sv
// Score stages: three interpolated sigmoids, their product, scaling and clamp.
module cvs_score
   import cvs_pkg::*;
#(
   parameter int SCORE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ctl_type                in_ctl,
   input  ratio_type [Lanes-1:0]  in_ratio,
   input  logic                   model_sel,
   input  logic [15:0]            cos_vert,
   input  logic [15:0]            cos_horiz,
   output ctl_type                out_ctl,
   output logic [SCORE_WIDTH-1:0] out_score
);

   localparam int DiffWidth  = RatioWidth + 2;
   localparam int ArgWidth   = 23;
   localparam int AbsWidth   = ArgWidth - 1;
   localparam int FracWidth  = 14;
   localparam int ProdWidth  = 2 * FracWidth;
   localparam int P12Width   = 2 * SigWidth;
   localparam int P123Width  = 3 * SigWidth;
   localparam int ScaleWidth = SigWidth + SCORE_WIDTH;

   ctl_type ctla_ff, ctlb_ff, ctlc_ff, ctld_ff, ctle_ff, ctlf_ff;

   logic signed [ArgWidth-1:0]  arga_in [Lanes];
   logic signed [ArgWidth-1:0]  arga_ff [Lanes];
   logic signed [DiffWidth-1:0] rsig    [Lanes];
   logic signed [DiffWidth-1:0] thr     [Lanes];
   logic signed [DiffWidth-1:0] diff    [Lanes];

   logic [AbsWidth-1:0]  mag      [Lanes];
   logic [3:0]           node_idx [Lanes];
   logic [FracWidth-1:0] frac     [Lanes];
   sig_type              node_lo  [Lanes];
   sig_type              node_hi  [Lanes];
   logic [FracWidth-1:0] delta    [Lanes];
   logic [Lanes-1:0]     negb_in, negb_ff, satb_in, satb_ff;
   sig_type              lob_ff   [Lanes];
   logic [ProdWidth-1:0] prodb_in [Lanes];
   logic [ProdWidth-1:0] prodb_ff [Lanes];

   sig_type sig_val [Lanes];
   sig_type sigc_in [Lanes];
   sig_type sigc_ff [Lanes];

   logic [P12Width-1:0]  p12d_in, p12d_ff;
   sig_type              s3d_ff, sad_ff;
   logic [P123Width-1:0] p123;
   sig_type              qe_in, qe_ff;

   logic [ScaleWidth-1:0]  scaled;
   logic [SCORE_WIDTH-1:0] scoref_in, scoref_ff;

   // Pick each lane's signed ratio and threshold, scale the difference by the gain
   always_comb begin
      rsig[LaneVert]  = $signed({2'b00, (model_sel == ModelConical) ?
                                 in_ratio[LaneAxis] : in_ratio[LaneVert]});
      if (model_sel == ModelConical && in_ctl.x_neg) rsig[LaneVert] = -rsig[LaneVert];
      rsig[LaneAxis]  = $signed({2'b00, in_ratio[LaneAxis]});
      if (in_ctl.x_neg) rsig[LaneAxis] = -rsig[LaneAxis];
      rsig[LaneHoriz] = $signed({2'b00, in_ratio[LaneHoriz]});
      thr[LaneVert]   = $signed({2'b00, cos_vert});
      thr[LaneAxis]   = '0;
      thr[LaneHoriz]  = $signed({2'b00, cos_horiz});
      for (int l = 0; l < Lanes; l++) begin
         diff[l]    = rsig[l] - thr[l];
         arga_in[l] = ArgWidth'(diff[l]) * ArgWidth'($signed({1'b0, SigGain[l]}));
      end
   end

   // Split the magnitude into node index and fraction, form the slope term
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         negb_in[l]  = arga_ff[l][ArgWidth-1];
         mag[l]      = AbsWidth'(negb_in[l] ? -arga_ff[l] : arga_ff[l]);
         satb_in[l]  = mag[l][AbsWidth-1:FracWidth+4] != '0;
         node_idx[l] = mag[l][FracWidth+3:FracWidth];
         frac[l]     = mag[l][FracWidth-1:0];
         node_lo[l]  = sig_node({1'b0, node_idx[l]});
         node_hi[l]  = sig_node({1'b0, node_idx[l]} + 5'd1);
         delta[l]    = FracWidth'(node_hi[l] - node_lo[l]);
         prodb_in[l] = ProdWidth'(delta[l]) * ProdWidth'(frac[l]);
      end
   end

   // Interpolate and mirror for negative arguments
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         sig_val[l] = satb_ff[l] ? SigOne :
                      lob_ff[l] + SigWidth'(prodb_ff[l][ProdWidth-1:FracWidth]);
         sigc_in[l] = negb_ff[l] ? SigOne - sig_val[l] : sig_val[l];
      end
   end

   // Product of the three sigmoids, conical mode takes the first alone
   always_comb begin
      p12d_in = P12Width'(sigc_ff[LaneVert]) * P12Width'(sigc_ff[LaneAxis]);
      p123    = P123Width'(p12d_ff) * P123Width'(s3d_ff);
      qe_in   = (model_sel == ModelConical) ? sad_ff : p123[2*P12Width-20 -: SigWidth];
   end

   // Rescale to the output width, clamp full score, force zero at the origin
   always_comb begin
      scaled = (ScaleWidth'(qe_ff) << SCORE_WIDTH) >> 16;
      if (scaled[ScaleWidth-1:SCORE_WIDTH] != '0) begin
         scoref_in = '1;
      end else begin
         scoref_in = SCORE_WIDTH'(scaled);
      end
      if (ctle_ff.zero) scoref_in = '0;
   end

   // Advance control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctla_ff <= '0;
         ctlb_ff <= '0;
         ctlc_ff <= '0;
         ctld_ff <= '0;
         ctle_ff <= '0;
         ctlf_ff <= '0;
      end else if (advance) begin
         ctla_ff <= in_ctl;
         ctlb_ff <= ctla_ff;
         ctlc_ff <= ctlb_ff;
         ctld_ff <= ctlc_ff;
         ctle_ff <= ctld_ff;
         ctlf_ff <= ctle_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < Lanes; l++) begin
            arga_ff[l]  <= arga_in[l];
            lob_ff[l]   <= node_lo[l];
            prodb_ff[l] <= prodb_in[l];
            sigc_ff[l]  <= sigc_in[l];
         end
         negb_ff   <= negb_in;
         satb_ff   <= satb_in;
         p12d_ff   <= p12d_in;
         s3d_ff    <= sigc_ff[LaneHoriz];
         sad_ff    <= sigc_ff[LaneVert];
         qe_ff     <= qe_in;
         scoref_ff <= scoref_in;
      end
   end

   assign out_ctl   = ctlf_ff;
   assign out_score = scoref_ff;

endmodule

>>> rtl/core/camera_visibility_score_top.sv
// Top level of the camera visibility score block: handshakes, registers, pipeline.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_pos_x, req_pos_y, req_pos_z
//   rsp_      out        rsp_valid / rsp_stall  rsp_visibility, rsp_zero_vector
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One request per cycle unless req_stall is high; each result passes the front stages,
// the 31-stage quotient pipeline, the 16-stage square-root pipeline and the score stages.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipeline, and req_stall follows at once.
// csr_ready is always high.
`include "camera_visibility_score_top_assert.svh"

module camera_visibility_score_top
   import cvs_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int SCORE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SCORE_WIDTH-1:0]        rsp_visibility,
   output logic                          rsp_zero_vector,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CsrIndexWidth-1:0]      csr_index,
   input  logic [15:0]                   csr_wdata
);

   logic        advance;
   logic        model_select_ff;
   logic [15:0] cos_vert_ff, cos_horiz_ff;

   ctl_type               front_ctl, ratio_ctl, score_ctl;
   norm_type              front_den;
   norm_type [Lanes-1:0]  front_num;
   ratio_type [Lanes-1:0] ratio_val;
   logic [SCORE_WIDTH-1:0] score_val;

   logic                   rsp_valid_ff;
   logic                   rsp_zero_ff;
   logic [SCORE_WIDTH-1:0] rsp_score_ff;

   // Move the pipeline whenever the output register is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Write configuration registers, ignore indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         model_select_ff <= ModelProposed;
         cos_vert_ff     <= CosVertReset;
         cos_horiz_ff    <= CosHorizReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CfgModelSelect: model_select_ff <= csr_wdata[0];
            CfgCosVert:     cos_vert_ff     <= csr_wdata;
            CfgCosHoriz:    cos_horiz_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   cvs_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .out_ctl  (front_ctl),
      .out_den  (front_den),
      .out_num  (front_num)
   );

   cvs_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (front_ctl),
      .in_den    (front_den),
      .in_num    (front_num),
      .out_ctl   (ratio_ctl),
      .out_ratio (ratio_val)
   );

   cvs_score #(
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (ratio_ctl),
      .in_ratio  (ratio_val),
      .model_sel (model_select_ff),
      .cos_vert  (cos_vert_ff),
      .cos_horiz (cos_horiz_ff),
      .out_ctl   (score_ctl),
      .out_score (score_val)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= score_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_zero_ff  <= score_ctl.zero;
         rsp_score_ff <= score_val;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visibility  = rsp_score_ff;
   assign rsp_zero_vector = rsp_zero_ff;

   `CVS_ASSERT_NOW(a_zero_scores_nil, clock, reset, rsp_valid && rsp_zero_vector, rsp_visibility == '0, "origin result with nonzero score")
   `CVS_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled while output free")
   `CVS_ASSERT_NEXT(a_mode_write, clock, reset, csr_valid && csr_ready && csr_index == CfgModelSelect, model_select_ff == $past(csr_wdata[0]), "model select write lost")

endmodule

>>> tb/tb_camera_visibility_score_top.sv
// Self-checking testbench for the camera visibility score block.
`timescale 1ns / 100ps

module tb_camera_visibility_score_top;
   import cvs_pkg::*;

   localparam int CoordWidth = 16;
   localparam int ScoreWidth = 16;
   localparam int Latency    = 59;
   localparam int IdleLimit  = 4000;
   localparam logic [CsrIndexWidth-1:0] CfgUnused = 2'd3;

   // Logistic nodes at half steps of the argument.
   localparam longint LogisticNode [17] = '{
      32768, 40793, 47910, 53581, 57724, 60564, 62428, 63615, 64357,
      64816, 65097, 65269, 65374, 65438, 65476, 65500, 65536};

   typedef struct {
      logic [ScoreWidth-1:0] visibility;
      logic                  zero_vector;
   } score_type;

   // Predicts scores for accepted points and checks arriving results.
   class visibility_scoreboard;
      score_type   score_q[$];
      logic        model;
      logic [15:0] cos_vert;
      logic [15:0] cos_horiz;
      int          errors;

      function new();
         model     = ModelProposed;
         cos_vert  = CosVertReset;
         cos_horiz = CosHorizReset;
         errors    = 0;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [15:0] data);
         if (idx == CfgModelSelect) model = data[0];
         else if (idx == CfgCosVert) cos_vert = data;
         else if (idx == CfgCosHoriz) cos_horiz = data;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      // sqrt(num/den) in Q1.15
      function longint direction_ratio(longint unsigned num, longint unsigned den);
         while ((den >> 32) != 0) begin
            den >>= 1;
            num >>= 1;
         end
         return longint'(int_sqrt((num << 30) / den));
      endfunction

      function longint logistic(longint gain, longint r, longint thr);
         longint          d;
         longint unsigned ad;
         longint unsigned idx;
         longint          frac;
         longint          val;
         d   = gain * (r - thr);
         ad  = d < 0 ? -d : d;
         idx = ad >> 14;
         if (idx >= 16) begin
            val = 65536;
         end else begin
            frac = longint'(ad & 16383);
            val  = LogisticNode[idx] +
                   (((LogisticNode[idx+1] - LogisticNode[idx]) * frac) >>> 14);
         end
         return d < 0 ? 65536 - val : val;
      endfunction

      function void note_request(logic signed [CoordWidth-1:0] x,
                                 logic signed [CoordWidth-1:0] y,
                                 logic signed [CoordWidth-1:0] z);
         longint          ax, ay, az, rx, r1, r3;
         longint unsigned xx, yy, zz, len2, q;
         score_type       score;
         ax   = x < 0 ? -longint'(x) : longint'(x);
         ay   = y < 0 ? -longint'(y) : longint'(y);
         az   = z < 0 ? -longint'(z) : longint'(z);
         xx   = ax * ax;
         yy   = ay * ay;
         zz   = az * az;
         len2 = xx + yy + zz;
         if (len2 == 0) begin
            score.visibility  = '0;
            score.zero_vector = 1'b1;
         end else begin
            rx = direction_ratio(xx, len2);
            if (x < 0) rx = -rx;
            if (model == ModelConical) begin
               q = logistic(40, rx, cos_vert);
            end else begin
               r1 = direction_ratio(xx + yy, len2);
               r3 = direction_ratio(xx + zz, len2);
               q  = (longint'(logistic(40, r1, cos_vert)) * logistic(10, rx, 0) *
                     logistic(20, r3, cos_horiz)) >> 32;
            end
            q = (q << ScoreWidth) >> 16;
            if (q > (64'd1 << ScoreWidth) - 1) q = (64'd1 << ScoreWidth) - 1;
            score.visibility  = q[ScoreWidth-1:0];
            score.zero_vector = 1'b0;
         end
         score_q.insert(score_q.size(), score);
      endfunction

      function void check_result(logic [ScoreWidth-1:0] vis, logic zero);
         score_type want;
         if (score_q.size() == 0) begin
            $error("unexpected result: visibility %0d zero_vector %0d", vis, zero);
            errors++;
            return;
         end
         want = score_q.pop_front();
         if (vis !== want.visibility) begin
            $error("visibility: expected %0d actual %0d", want.visibility, vis);
            errors++;
         end
         if (zero !== want.zero_vector) begin
            $error("zero_vector: expected %0d actual %0d", want.zero_vector, zero);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [CoordWidth-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [ScoreWidth-1:0]        rsp_visibility;
   logic                         rsp_zero_vector;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CsrIndexWidth-1:0]     csr_index;
   logic [15:0]                  csr_wdata;

   visibility_scoreboard score_board = new();
   int  stall_left;
   int  rsp_wait;
   bit  quiet;
   int  idle_cycles;

   camera_visibility_score_top #(
      .COORD_WIDTH(CoordWidth),
      .SCORE_WIDTH(ScoreWidth)
   ) dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check results, then hold off the next one by a randomly drawn stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         score_board.check_result(rsp_visibility, rsp_zero_vector);
         rsp_wait = quiet ? 0 : $urandom_range(16);
         stall_left <= rsp_wait;
         rsp_stall  <= (rsp_wait != 0);
      end else if (stall_left > 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end
   end

   // End the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_point(logic signed [CoordWidth-1:0] x,
                             logic signed [CoordWidth-1:0] y,
                             logic signed [CoordWidth-1:0] z);
      int gap;
      gap = quiet ? 0 : $urandom_range(16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (req_stall);
      score_board.note_request(x, y, z);
   endtask

   // Hold requests until every result is back, then let the pipe empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (score_board.score_q.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      score_board.set_reg(idx, data);
   endtask

   task automatic configure(logic model, logic [15:0] vert, logic [15:0] horiz);
      write_reg(CfgModelSelect, {15'd0, model});
      write_reg(CfgCosVert, vert);
      write_reg(CfgCosHoriz, horiz);
   endtask

   task automatic send_random();
      logic signed [CoordWidth-1:0] x, y, z;
      int sel;
      sel = $urandom_range(9);
      x   = CoordWidth'($urandom);
      y   = CoordWidth'($urandom);
      z   = CoordWidth'($urandom);
      // bias toward small magnitudes and points near the axis
      if (sel < 2) begin
         x = CoordWidth'($signed($urandom_range(8)) - 4);
         y = CoordWidth'($signed($urandom_range(8)) - 4);
         z = CoordWidth'($signed($urandom_range(8)) - 4);
      end else if (sel < 4) begin
         y = y >>> $urandom_range(15);
         z = z >>> $urandom_range(15);
      end
      send_point(x, y, z);
   endtask

   task automatic directed_points();
      send_point(16'sd0, 16'sd0, 16'sd0);
      send_point(16'sh7fff, 16'sd0, 16'sd0);
      send_point(-16'sh8000, 16'sd0, 16'sd0);
      send_point(16'sd0, 16'sh7fff, 16'sd0);
      send_point(16'sd0, 16'sd0, -16'sh8000);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(-16'sh8000, -16'sh8000, -16'sh8000);
      send_point(16'sd1, 16'sd0, 16'sd0);
      send_point(-16'sd1, 16'sd1, -16'sd1);
      send_point(16'sd0, 16'sd0, 16'sd1);
      send_point(16'sh7fff, -16'sh8000, 16'sh7fff);
      send_point(16'sd100, 16'sd40, 16'sd70);
   endtask

   initial begin
      int phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Run the directed points on reset defaults, then in conical mode.
      directed_points();
      drain();
      write_reg(CfgUnused, 16'hffff);
      configure(ModelConical, CosVertReset, CosHorizReset);
      directed_points();
      drain();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(ModelProposed, CosVertReset, CosHorizReset);
            1: configure(ModelConical, 16'd0, 16'd0);
            2: configure(ModelProposed, 16'd32768, 16'd32768);
            3: configure(ModelProposed, 16'hffff, 16'hffff);
            4: configure(ModelConical, 16'hffff, 16'd0);
            5: configure(ModelProposed, 16'd0, 16'hffff);
            default: configure(1'($urandom_range(1)), 16'($urandom),
                               16'($urandom_range(32768)));
         endcase
         repeat (115) begin
            if ($urandom_range(40) == 0) quiet = ~quiet;
            send_random();
         end
         quiet = 1'b0;
         drain();
      end

      if (score_board.errors == 0 && score_board.score_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> camera_visibility_score_top.f
+incdir+rtl/core
rtl/core/cvs_pkg.sv
rtl/core/cvs_front.sv
rtl/core/cvs_ratio.sv
rtl/core/cvs_score.sv
rtl/core/camera_visibility_score_top.sv
tb/tb_camera_visibility_score_top.sv
